// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define APR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define APR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/apr_pkg.sv =====
`default_nettype none

package apr_pkg;

    localparam int FRAME_W = 7;
    localparam int CFG_W   = 8;
    localparam int AGE_W   = 32;
    // Frames reachable through a frame index.
    localparam int FRAME_SPAN = 1 << FRAME_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    localparam logic [1:0] ACT_REFERENCE = 2'd0;
    localparam logic [1:0] ACT_MAP       = 2'd1;
    localparam logic [1:0] ACT_FREE      = 2'd2;
    localparam logic [1:0] ACT_VICTIM    = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [FRAME_W-1:0] frame_index;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic               victim_valid;
    } rsp_t;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic             referenced;
        logic             in_use;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== sv/apr_ram.sv =====
`default_nettype none

module apr_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/aging_page_replacement.sv =====
// Channel | Signals                          | Direction | Moves
// req     | req_valid, req_ready, req        | in        | one action item
// rsp     | rsp_valid, rsp_ready, rsp        | out       | one victim item
// cfg     | cfg_valid, cfg_ready, cfg_data   | in        | frames_in_use write
//
// Reference, map and free read the entry, then write it back;
// an index at or beyond the active count is dropped in the accept cycle.
// A victim request reads m frames, m = min(active count, 128): one age
// memory read is issued per cycle and aged, compared and written back the next.
// Reset clears the state at once through per-entry valid bits; no sweep.
// rsp has an output register: req is taken while a result waits, and a later
// victim holds in its last cycle until the output register frees.
`default_nettype none

module aging_page_replacement #(
    parameter int MAX_FRAMES = 128
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire apr_pkg::req_t              req,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output apr_pkg::rsp_t                   rsp,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [apr_pkg::CFG_W-1:0]  cfg_data
);

    import apr_pkg::*;

    `include "assert_macros.svh"

    localparam int DEPTH  = (MAX_FRAMES < FRAME_SPAN) ? MAX_FRAMES : FRAME_SPAN;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = $clog2(1024 + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic [FRAME_W-1:0] hand_reg, hand_next;
    logic [1:0]         op_reg, op_next;
    logic [FRAME_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]   issued_reg, issued_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [ADDR_W-1:0]  proc_addr_reg, proc_addr_next;
    logic               found_reg, found_next;
    logic [AGE_W-1:0]   min_reg, min_next;
    logic [ADDR_W-1:0]  best_reg, best_next;
    logic [DEPTH-1:0]   valid_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic [CFG_W-1:0]   n_act;
    logic [CNT_W-1:0]   m_act;
    logic [FRAME_W-1:0] hand_start;
    logic               req_fire;
    logic               issue;
    logic               load;
    logic [CFG_W-1:0]   hand_sum;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    entry_t             rd_entry;
    entry_t             aged;
    entry_t             updated;
    logic               better;

    apr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Clamp the frame count to 1..MAX_FRAMES; only the first DEPTH frames hold data.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_act = CFG_W'(1);
        end
        else if (WIDE_W'(cfg_reg) > WIDE_W'(MAX_FRAMES))
        begin
            n_act = CFG_W'(MAX_FRAMES);
        end
        else
        begin
            n_act = cfg_reg;
        end
        m_act = (n_act > CFG_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(n_act);
        hand_start = (CFG_W'(hand_reg) < n_act) ? hand_reg : '0;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign issue     = (state_reg == S_SCAN) && (issued_reg != m_act);
    assign load      = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // Entries never written since reset read as zero.
    always_comb
    begin
        rd_entry = valid_reg[proc_addr_reg] ? entry_t'(ram_rd_data) : '0;
        aged = rd_entry;
        if (rd_entry.in_use)
        begin
            aged.age        = {rd_entry.referenced, rd_entry.age[AGE_W-1:1]};
            aged.referenced = 1'b0;
        end
        better = aged.in_use && (!found_reg || (aged.age < min_reg));

        updated = rd_entry;
        case (op_reg)
            ACT_REFERENCE:
            begin
                updated.referenced = 1'b1;
            end
            ACT_MAP:
            begin
                updated.in_use = 1'b1;
                updated.age    = '0;
            end
            ACT_FREE:
            begin
                updated.in_use = 1'b0;
            end
            default:
            begin
                updated = rd_entry;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        hand_next       = hand_reg;
        op_next         = op_reg;
        start_next      = start_reg;
        ptr_next        = ptr_reg;
        issued_next     = issued_reg;
        proc_valid_next = 1'b0;
        proc_addr_next  = proc_addr_reg;
        found_next      = found_reg;
        min_next        = min_reg;
        best_next       = best_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = ptr_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = proc_addr_reg;
        ram_wr_data     = aged;
        hand_sum        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next = req.action;
                    if (req.action == ACT_VICTIM)
                    begin
                        start_next  = hand_start;
                        ptr_next    = hand_start[ADDR_W-1:0];
                        issued_next = '0;
                        found_next  = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else if (CFG_W'(req.frame_index) < n_act)
                    begin
                        ram_rd_en      = 1'b1;
                        ram_rd_addr    = req.frame_index[ADDR_W-1:0];
                        proc_addr_next = req.frame_index[ADDR_W-1:0];
                        state_next     = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = updated;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                // Read the next frame while the previous one is aged and written back.
                if (issue)
                begin
                    ram_rd_en       = 1'b1;
                    proc_valid_next = 1'b1;
                    proc_addr_next  = ptr_reg;
                    issued_next     = issued_reg + 1'b1;
                    ptr_next        = (CNT_W'(ptr_reg) + 1'b1 == m_act) ?
                                      '0 : ptr_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
                if (proc_valid_reg)
                begin
                    ram_wr_en = 1'b1;
                    if (better)
                    begin
                        found_next = 1'b1;
                        min_next   = aged.age;
                        best_next  = proc_addr_reg;
                    end
                end
            end
            S_DONE:
            begin
                hand_sum = (found_reg ? CFG_W'(best_reg) : CFG_W'(start_reg)) + 1'b1;
                if (load)
                begin
                    hand_next  = (hand_sum >= n_act) ? '0 : hand_sum[FRAME_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_reg        <= CFG_RESET;
            hand_reg       <= '0;
            proc_valid_reg <= 1'b0;
            issued_reg     <= '0;
            found_reg      <= 1'b0;
            valid_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hand_reg       <= hand_next;
            proc_valid_reg <= proc_valid_next;
            issued_reg     <= issued_next;
            found_reg      <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            if (ram_wr_en)
            begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        start_reg     <= start_next;
        ptr_reg       <= ptr_next;
        proc_addr_reg <= proc_addr_next;
        min_reg       <= min_next;
        best_reg      <= best_next;
        if (load)
        begin
            rsp_reg.victim_frame <= found_reg ? FRAME_W'(best_reg) : '0;
            rsp_reg.victim_valid <= found_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `APR_ASSERT_IMP(a_no_rw_clash, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "read and write hit the same frame in one cycle")
    `APR_ASSERT_IMP(a_issue_bound, state_reg == S_SCAN, issued_reg <= m_act, "scan issued more reads than active frames")
    `APR_ASSERT_NXT(a_empty_rsp, load && !found_reg, rsp.victim_frame == '0, "empty victim item carries a frame")

endmodule

`default_nettype wire
